// ----- rtl/tpsa_pkg.sv -----
// Shared codes for the two-level page/slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package tpsa_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC_PAGE = 3'd0,
    CMD_FREE_PAGE  = 3'd1,
    CMD_ALLOC_SLOT = 3'd2,
    CMD_FREE_SLOT  = 3'd3,
    CMD_QUERY      = 3'd4,
    CMD_PLACE_NEAR = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_EXH  = 2'd2,
    STAT_BAD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_SLOT_CAP  = 2'd0,
    CFG_INIT_PGS  = 2'd1,
    CFG_GROW_PGS  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_TAKE,
    S_GROW,
    S_TAKE_RD,
    S_PAGE_RD,
    S_LINK_RD
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/tpsa_ram.sv -----
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tpsa_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/two_level_page_slot_allocator.sv -----
// Top level: command sequencer of the two-level page/slot allocator.
`timescale 1ns / 1ps
`default_nettype none
// Page/slot allocator. One command at a time: start is taken while busy is
// low, and exactly one result word comes back on the result ports with done_o
// high for a single cycle; there is no backpressure on results, so capture them.
// All per-page state (in-use flag, free-list link, slot free-list top, used
// count, latched capacity, per-slot in-use bits) lives in one page RAM word;
// slot free-list links live in a second RAM. Both have registered read ports.
// An unknown command or a page outside the pool ends at dispatch; query,
// free page, free slot and alloc slot read the page RAM word, and a slot
// reused from the slot free list takes one more link RAM read. Alloc page
// and place near without a usable chain page take a page from the free
// list. A page request that finds the free list empty first grows the
// pool, writing one new page entry per cycle (first or later growth count,
// at least one, capped at the pages still missing up to NUM_PAGES), then
// looks at the free list again; with a full pool the request reports
// exhaustion.
// Configuration writes are always ready and take effect at once; write them
// only while the block is idle.
module two_level_page_slot_allocator
  import tpsa_pkg::*;
#(
  parameter int NUM_PAGES      = 64,
  parameter int SLOTS_PER_PAGE = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] cmd_i,
  input  wire logic [5:0] page_id_i,
  input  wire logic [4:0] slot_id_i,
  input  wire logic       chain_present_i,
  output logic            done_o,
  output logic [1:0]      status_o,
  output logic [5:0]      page_out_o,
  output logic [4:0]      slot_out_o,
  output logic [5:0]      used_slots_o,
  output logic            slot_available_o,
  output logic [6:0]      pages_in_pool_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [6:0] cfg_data_i
);

  localparam int S    = SLOTS_PER_PAGE;
  localparam int PIW  = $clog2(NUM_PAGES);
  localparam int PW   = $clog2(NUM_PAGES + 1);
  localparam int SIW  = (S > 1) ? $clog2(S) : 1;
  localparam int SW   = $clog2(S + 1);
  localparam int LD   = NUM_PAGES * S;
  localparam int LAW  = $clog2(LD);
  localparam int EW   = 1 + PW + 3 * SW + S;
  // page word: {busy, link, top, used, cap, bits}
  localparam int O_LINK = EW - 2;
  localparam int O_TOP  = EW - 2 - PW;
  localparam int O_USED = EW - 2 - PW - SW;
  localparam int O_CAP  = S + SW - 1;
  localparam logic [PW-1:0] NO_PAGE = PW'(NUM_PAGES);
  localparam logic [SW-1:0] NO_SLOT = SW'(S);

  state_e state_q, state_d;

  logic [2:0]    cmd_q;
  logic [5:0]    pid_q;
  logic [4:0]    sid_q;
  logic          chain_q;
  logic [PW-1:0] free_top_q, free_top_d;
  logic [PW-1:0] pool_q, pool_d;
  logic [PW-1:0] grow_q, grow_d;
  logic [EW-1:0] ent_q, ent_d;
  logic [5:0]    cfg_cap_q;
  logic [6:0]    cfg_init_q, cfg_grow_q;

  logic          fin, to_page, to_grow, to_link;
  logic [1:0]    res_status;
  logic [5:0]    res_page;
  logic [4:0]    res_slot;
  logic [5:0]    res_used;
  logic          res_avail;

  // RAM ports
  logic          pg_we, pg_re;
  logic [PIW-1:0] pg_waddr, pg_raddr;
  logic [EW-1:0] pg_wdata, pg_rdata;
  logic          lk_we, lk_re;
  logic [LAW-1:0] lk_waddr, lk_raddr;
  logic [SW-1:0] lk_wdata, lk_rdata;

  tpsa_ram #(.DW(EW), .DEPTH(NUM_PAGES)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pg_we),
    .waddr_i (pg_waddr),
    .wdata_i (pg_wdata),
    .re_i    (pg_re),
    .raddr_i (pg_raddr),
    .rdata_o (pg_rdata)
  );

  tpsa_ram #(.DW(SW), .DEPTH(LD)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .re_i    (lk_re),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  // entry fields; the link read state works on the latched copy
  logic [EW-1:0] src;
  logic          e_busy, e_room;
  logic [PW-1:0] e_link;
  logic [SW-1:0] e_top, e_used, e_cap;
  logic [S-1:0]  e_bits;

  assign src    = (state_q == S_LINK_RD) ? ent_q : pg_rdata;
  assign e_busy = src[EW-1];
  assign e_link = src[O_LINK -: PW];
  assign e_top  = src[O_TOP -: SW];
  assign e_used = src[O_USED -: SW];
  assign e_cap  = src[O_CAP -: SW];
  assign e_bits = src[S-1:0];
  assign e_room = (e_top != NO_SLOT) || (e_used < e_cap);

  // capacity latched by a page reset, clamped to 1..S
  logic [SW-1:0] cap_eff;
  always_comb begin
    if (cfg_cap_q == 6'd0) begin
      cap_eff = SW'(1);
    end else if (32'(cfg_cap_q) > S) begin
      cap_eff = NO_SLOT;
    end else begin
      cap_eff = SW'(cfg_cap_q);
    end
  end

  // pages to add at a growth
  logic [6:0]    n_sel;
  logic [PW-1:0] room, n_grow;
  always_comb begin
    n_sel = (pool_q == '0) ? cfg_init_q : cfg_grow_q;
    if (n_sel == 7'd0) begin
      n_sel = 7'd1;
    end
    room = NO_PAGE - pool_q;
    if (32'(n_sel) > 32'(room)) begin
      n_grow = room;
    end else begin
      n_grow = PW'(n_sel);
    end
  end

  logic           in_pool, sid_ok;
  logic [PIW-1:0] pidx;
  logic [SIW-1:0] sidx;
  logic [S-1:0]   sbit;
  logic [SW-1:0]  used_inc;
  assign in_pool  = 32'(pid_q) < 32'(pool_q);
  assign pidx     = PIW'(pid_q);
  assign sidx     = SIW'(sid_q);
  assign sid_ok   = 32'(sid_q) < S;
  assign used_inc = e_used + SW'(1);

  // datapath and RAM control
  always_comb begin
    fin        = 1'b0;
    to_page    = 1'b0;
    to_grow    = 1'b0;
    to_link    = 1'b0;
    free_top_d = free_top_q;
    pool_d     = pool_q;
    grow_d     = grow_q;
    ent_d      = ent_q;
    pg_we      = 1'b0;
    pg_re      = 1'b0;
    pg_waddr   = pidx;
    pg_raddr   = pidx;
    pg_wdata   = '0;
    lk_we      = 1'b0;
    lk_re      = 1'b0;
    lk_waddr   = LAW'(pidx) * LAW'(S) + LAW'(sidx);
    lk_raddr   = LAW'(pidx) * LAW'(S) + LAW'(SIW'(e_top));
    lk_wdata   = e_top;
    sbit       = '0;
    res_status = STAT_OK;
    res_page   = pid_q;
    res_slot   = 5'd0;
    res_used   = 6'd0;
    res_avail  = 1'b0;
    case (state_q)
      S_DISP: begin
        case (cmd_q)
          CMD_ALLOC_PAGE: ;
          CMD_FREE_PAGE, CMD_ALLOC_SLOT, CMD_FREE_SLOT, CMD_QUERY: begin
            if (!in_pool) begin
              fin        = 1'b1;
              res_status = STAT_BAD;
            end else begin
              to_page = 1'b1;
              pg_re   = 1'b1;
            end
          end
          CMD_PLACE_NEAR: begin
            if (chain_q && !in_pool) begin
              fin        = 1'b1;
              res_status = STAT_BAD;
            end else if (chain_q) begin
              to_page = 1'b1;
              pg_re   = 1'b1;
            end
          end
          default: begin
            fin        = 1'b1;
            res_status = STAT_BAD;
            res_page   = 6'd0;
          end
        endcase
      end
      S_TAKE: begin
        if (free_top_q == NO_PAGE) begin
          if (pool_q == NO_PAGE) begin
            fin        = 1'b1;
            res_status = STAT_EXH;
            res_page   = 6'd0;
          end else begin
            to_grow = 1'b1;
            grow_d  = n_grow;
          end
        end else begin
          pg_re    = 1'b1;
          pg_raddr = PIW'(free_top_q);
        end
      end
      S_GROW: begin
        // newest page ends on top of the free list
        pg_we      = 1'b1;
        pg_waddr   = PIW'(pool_q);
        pg_wdata   = {1'b0, free_top_q, NO_SLOT, SW'(0), cap_eff, S'(0)};
        free_top_d = pool_q;
        pool_d     = pool_q + PW'(1);
        grow_d     = grow_q - PW'(1);
      end
      S_TAKE_RD: begin
        fin        = 1'b1;
        free_top_d = e_link;
        pg_we      = 1'b1;
        pg_waddr   = PIW'(free_top_q);
        res_page   = 6'(free_top_q);
        if (cmd_q == CMD_ALLOC_PAGE) begin
          pg_wdata  = {1'b1, e_link, NO_SLOT, SW'(0), cap_eff, S'(0)};
          res_avail = 1'b1;
        end else begin
          // fresh page for place-near: slot 0 goes out at once
          pg_wdata  = {1'b1, e_link, NO_SLOT, SW'(1), cap_eff, S'(1)};
          res_used  = 6'd1;
          res_avail = cap_eff > SW'(1);
        end
      end
      S_PAGE_RD: begin
        ent_d = pg_rdata;
        case (cmd_q)
          CMD_FREE_PAGE: begin
            fin = 1'b1;
            if (!e_busy) begin
              res_status = STAT_BAD;
            end else begin
              pg_we      = 1'b1;
              pg_wdata   = {1'b0, free_top_q, NO_SLOT, SW'(0), cap_eff, S'(0)};
              free_top_d = PW'(pid_q);
              res_avail  = 1'b1;
            end
          end
          CMD_QUERY: begin
            fin       = 1'b1;
            res_used  = 6'(e_used);
            res_avail = e_room;
          end
          CMD_FREE_SLOT: begin
            fin = 1'b1;
            if (!e_busy || !sid_ok || !e_bits[sidx]) begin
              res_status = STAT_BAD;
            end else begin
              sbit      = S'(1) << sidx;
              lk_we     = 1'b1;
              pg_we     = 1'b1;
              pg_wdata  = {1'b1, e_link, SW'(sidx), e_used - SW'(1), e_cap,
                           e_bits & ~sbit};
              res_slot  = sid_q;
              res_used  = 6'(e_used - SW'(1));
              res_avail = 1'b1;
            end
          end
          CMD_ALLOC_SLOT, CMD_PLACE_NEAR: begin
            if (cmd_q == CMD_ALLOC_SLOT && !e_busy) begin
              fin        = 1'b1;
              res_status = STAT_BAD;
            end else if (cmd_q == CMD_PLACE_NEAR && !(e_busy && e_room)) begin
              // chain page unusable: take a new page
            end else if (e_top != NO_SLOT) begin
              to_link = 1'b1;
              lk_re   = 1'b1;
            end else if (e_used < e_cap) begin
              fin       = 1'b1;
              sbit      = S'(1) << SIW'(e_used);
              pg_we     = 1'b1;
              pg_wdata  = {1'b1, e_link, e_top, used_inc, e_cap, e_bits | sbit};
              res_slot  = 5'(e_used);
              res_used  = 6'(used_inc);
              res_avail = used_inc < e_cap;
            end else begin
              fin        = 1'b1;
              res_status = STAT_FULL;
              res_used   = 6'(e_used);
            end
          end
          default: begin
            fin        = 1'b1;
            res_status = STAT_BAD;
          end
        endcase
      end
      S_LINK_RD: begin
        fin       = 1'b1;
        sbit      = S'(1) << SIW'(e_top);
        pg_we     = 1'b1;
        pg_wdata  = {1'b1, e_link, lk_rdata, used_inc, e_cap, e_bits | sbit};
        res_slot  = 5'(e_top);
        res_used  = 6'(used_inc);
        res_avail = (lk_rdata != NO_SLOT) || (used_inc < e_cap);
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (start) state_d = S_DISP;
      S_DISP: begin
        if (fin) state_d = S_IDLE;
        else if (to_page) state_d = S_PAGE_RD;
        else state_d = S_TAKE;
      end
      S_TAKE: begin
        if (fin) state_d = S_IDLE;
        else if (to_grow) state_d = S_GROW;
        else state_d = S_TAKE_RD;
      end
      S_GROW:    if (grow_q == PW'(1)) state_d = S_TAKE;
      S_TAKE_RD: state_d = S_IDLE;
      S_PAGE_RD: begin
        if (fin) state_d = S_IDLE;
        else if (to_link) state_d = S_LINK_RD;
        else state_d = S_TAKE;
      end
      S_LINK_RD: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      free_top_q <= NO_PAGE;
      pool_q     <= '0;
      grow_q     <= '0;
      done_o     <= 1'b0;
      cfg_cap_q  <= 6'd32;
      cfg_init_q <= 7'd16;
      cfg_grow_q <= 7'd8;
    end else begin
      state_q    <= state_d;
      free_top_q <= free_top_d;
      pool_q     <= pool_d;
      grow_q     <= grow_d;
      done_o     <= fin;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SLOT_CAP: cfg_cap_q  <= cfg_data_i[5:0];
          CFG_INIT_PGS: cfg_init_q <= cfg_data_i;
          CFG_GROW_PGS: cfg_grow_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (state_q == S_IDLE && start) begin
      cmd_q   <= cmd_i;
      pid_q   <= page_id_i;
      sid_q   <= slot_id_i;
      chain_q <= chain_present_i;
    end
    if (fin) begin
      status_o         <= res_status;
      page_out_o       <= res_page;
      slot_out_o       <= res_slot;
      used_slots_o     <= res_used;
      slot_available_o <= res_avail;
      pages_in_pool_o  <= 7'(pool_d);
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // a command never finishes in back-to-back cycles
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("two results in a row");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted command not started");

  a_grow_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GROW) |-> (pool_q < NO_PAGE && grow_q != '0))
    else $error("pool growth past the pool size");

  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_top_q <= NO_PAGE) else $error("free list top out of range");

endmodule
`default_nettype wire
